// ----- src/swrc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the sliding-window receiver.
// No dependencies; swrc_classify and the top level use this package by scoped names.
package swrc_pkg;

    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int DEF_SEQ_BITS     = 16;

    localparam int FIELD_W   = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [FIELD_W-1:0] TOTAL_RESET = 16'd20000;

    // Classification of one request against the current window
    typedef struct packed {
        logic flagged;  // beyond window or total, ignore
        logic store;    // inside window, ahead of expected: mark flag
        logic hit;      // equals expected: mark and advance
    } class_t;

endpackage

// ----- src/swrc_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module swrc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/swrc_classify.sv -----
`timescale 1ns / 1ps
// Window classifier: effective total, window compares and ring index of a request.
// Depends on swrc_pkg.
module swrc_classify #(
    parameter int WINDOW_DEPTH = swrc_pkg::DEF_WINDOW_DEPTH,
    parameter int SEQ_BITS     = swrc_pkg::DEF_SEQ_BITS
) (
    input  logic [SEQ_BITS-1:0]              seq,
    input  logic [SEQ_BITS-1:0]              expected,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]  exp_idx,
    input  logic [swrc_pkg::FIELD_W-1:0]     total,
    output swrc_pkg::class_t                 cls,
    output logic [$clog2(WINDOW_DEPTH)-1:0]  idx,
    output logic [SEQ_BITS-1:0]              limit
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int TW    = (SEQ_BITS > swrc_pkg::FIELD_W) ? SEQ_BITS : swrc_pkg::FIELD_W;
    localparam int SW    = SEQ_BITS + IDX_W + 1;

    logic [TW-1:0]       total_ext;
    logic [TW-1:0]       mask_ext;
    logic [TW-1:0]       limit_ext;
    logic                beyond;
    logic                flagged;
    logic [SEQ_BITS-1:0] diff;
    logic [IDX_W:0]      idx_sum;

    // Cap the completion point so expected never leaves its width
    assign total_ext = TW'(total);
    assign mask_ext  = TW'({SEQ_BITS{1'b1}});
    assign limit_ext = (total_ext < mask_ext) ? total_ext : mask_ext;
    assign limit     = SEQ_BITS'(limit_ext);

    assign beyond  = SW'(seq) >= (SW'(expected) + SW'(WINDOW_DEPTH));
    assign flagged = (seq >= limit) || beyond;

    assign cls.flagged = flagged;
    assign cls.hit     = !flagged && (seq == expected);
    assign cls.store   = !flagged && (seq > expected);

    // Ring slot: offset from expected, wrapped once at the window depth
    assign diff    = seq - expected;
    assign idx_sum = (IDX_W+1)'(exp_idx) + (IDX_W+1)'(diff);
    assign idx     = (idx_sum >= (IDX_W+1)'(WINDOW_DEPTH))
                     ? IDX_W'(idx_sum - (IDX_W+1)'(WINDOW_DEPTH))
                     : IDX_W'(idx_sum);

endmodule

// ----- src/sliding_window_receiver_cumulative_ack.sv -----
`timescale 1ns / 1ps
// Top level of the sliding-window receiver with cumulative acknowledgment.
// Depends on swrc_pkg, swrc_classify and swrc_ram.
//
//   Channel   Signals                      Direction  Payload
//   -------   --------------------------   ---------  ---------------------------------
//   config    cfg_valid/cfg_ready/cfg_data  in         total_messages [15:0]
//   s         s_tvalid/s_tready/s_tdata     in         received_seq [15:0]
//   m         m_tvalid/m_tready/m_tdata     out        cumulative_ack [15:0],
//                                                     out_of_window [16], transfer_done [17]
//
// Sequence: a request is accepted in the idle state and classified in the check
// state. When it is marked ahead, repeated or flagged, the done state then loads
// its result into the output register; when it is the expected one, the test state
// first advances past every further marked ring entry, one flag RAM read per entry.
// Reset: after rst_n releases, a clearing pass writes every ring entry to zero
// while s_tready stays low; configuration writes are taken.
// Stalls: a held result in the output register does not block acceptance of the
// next request; only the final load waits for m_tready.
module sliding_window_receiver_cumulative_ack #(
    parameter int WINDOW_DEPTH = swrc_pkg::DEF_WINDOW_DEPTH,
    parameter int SEQ_BITS     = swrc_pkg::DEF_SEQ_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swrc_pkg::FIELD_W-1:0]      cfg_data,    // [15:0] total_messages
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swrc_pkg::FIELD_W-1:0]      s_tdata,     // [15:0] received_seq
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swrc_pkg::OUT_DATA_W-1:0]   m_tdata      // [15:0] cumulative_ack,
                                                           // [16] out_of_window,
                                                           // [17] transfer_done, rest 0
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_TEST  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [SEQ_BITS-1:0]             seq_reg, seq_next;
    logic [SEQ_BITS-1:0]             expected_reg, expected_next;
    logic [IDX_W-1:0]                exp_idx_reg, exp_idx_next;
    logic [SEQ_BITS-1:0]             last_ack_reg, last_ack_next;
    logic [swrc_pkg::FIELD_W-1:0]    total_reg, total_next;
    logic                            oow_reg, oow_next;
    logic                            m_valid_reg, m_valid_next;
    logic [swrc_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    swrc_pkg::class_t                cls;
    logic [IDX_W-1:0]                slot_idx;
    logic [SEQ_BITS-1:0]             limit;
    logic [IDX_W-1:0]                exp_inc;

    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    logic                            ram_wdata;
    logic                            ram_rdata;

    swrc_classify #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SEQ_BITS     (SEQ_BITS)
    ) u_classify (
        .seq      (seq_reg),
        .expected (expected_reg),
        .exp_idx  (exp_idx_reg),
        .total    (total_reg),
        .cls      (cls),
        .idx      (slot_idx),
        .limit    (limit)
    );

    // Received flags, one bit per ring slot
    swrc_ram #(
        .WIDTH (1),
        .DEPTH (WINDOW_DEPTH)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (exp_inc),
        .rdata (ram_rdata)
    );

    // Slot after the expected one, wrapped at the window depth
    assign exp_inc = (exp_idx_reg == IDX_W'(WINDOW_DEPTH - 1))
                     ? '0 : exp_idx_reg + IDX_W'(1);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        seq_next      = seq_reg;
        expected_next = expected_reg;
        exp_idx_next  = exp_idx_reg;
        last_ack_next = last_ack_reg;
        total_next    = total_reg;
        oow_next      = oow_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = exp_idx_reg;
        ram_wdata     = 1'b0;

        if (cfg_valid)
        begin
            total_next = cfg_data;
        end

        // Drop the held result once the sink takes it
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                if (clr_cnt_reg == IDX_W'(WINDOW_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    seq_next   = SEQ_BITS'(s_tdata);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                oow_next = cls.flagged;
                if (cls.hit)
                begin
                    // Consume the expected slot and start reading the next one
                    ram_we        = 1'b1;
                    expected_next = expected_reg + SEQ_BITS'(1);
                    exp_idx_next  = exp_inc;
                    state_next    = ST_TEST;
                end
                else if (cls.store)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_idx;
                    ram_wdata  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TEST:
            begin
                // Read data belongs to the slot of expected_reg
                if (ram_rdata && (expected_reg < limit))
                begin
                    ram_we        = 1'b1;
                    expected_next = expected_reg + SEQ_BITS'(1);
                    exp_idx_next  = exp_inc;
                end
                else
                begin
                    last_ack_next = expected_reg - SEQ_BITS'(1);
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, (expected_reg >= limit), oow_reg,
                                    swrc_pkg::FIELD_W'(last_ack_reg)};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            expected_reg <= '0;
            exp_idx_reg  <= '0;
            last_ack_reg <= '0;
            total_reg    <= swrc_pkg::TOTAL_RESET;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            expected_reg <= expected_next;
            exp_idx_reg  <= exp_idx_next;
            last_ack_reg <= last_ack_next;
            total_reg    <= total_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg    <= seq_next;
        oow_reg    <= oow_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- tb/sv/sliding_window_receiver_cumulative_ack_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window receiver with cumulative acknowledgment.
// Depends on swrc_pkg and the RTL top level; drives a directed table, then random windows.
module sliding_window_receiver_cumulative_ack_tb;

    localparam int WIN   = swrc_pkg::DEF_WINDOW_DEPTH;
    localparam int SEQ_W = swrc_pkg::FIELD_W;

    // One acknowledgment as it leaves the block
    typedef struct packed {
        logic [SEQ_W-1:0] cum_ack;
        logic             oow;
        logic             done;
    } ack_result_t;

    typedef enum logic {ROW_PKT, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e        kind;
        logic [SEQ_W-1:0] value;   // sequence number or total_messages
        logic             typed;   // expected result given in the row
        logic [SEQ_W-1:0] ack;
        logic             oow;
        logic             done;
    } dir_row_t;

    localparam int DIR_N = 20;

    // Directed walk: window edges, duplicates, beyond window and total,
    // total lowered under the expected number, zero total, full-range total.
    localparam dir_row_t DIRECTED [DIR_N] = '{
        '{ROW_PKT, 16'd0,     1'b1, 16'd0, 1'b0, 1'b0},  // first in order
        '{ROW_PKT, 16'hFFFF,  1'b1, 16'd0, 1'b1, 1'b0},  // far beyond window
        '{ROW_PKT, 16'd0,     1'b1, 16'd0, 1'b0, 1'b0},  // duplicate
        '{ROW_PKT, 16'd3,     1'b1, 16'd0, 1'b0, 1'b0},  // ahead, mark only
        '{ROW_PKT, 16'd2,     1'b1, 16'd0, 1'b0, 1'b0},
        '{ROW_PKT, 16'd64,    1'b1, 16'd0, 1'b0, 1'b0},  // last slot of the window
        '{ROW_PKT, 16'd65,    1'b1, 16'd0, 1'b1, 1'b0},  // first past the window
        '{ROW_PKT, 16'd1,     1'b1, 16'd3, 1'b0, 1'b0},  // advance over 1..3
        '{ROW_CFG, 16'd1,     1'b0, 16'd0, 1'b0, 1'b0},  // lower total below expected
        '{ROW_PKT, 16'd4,     1'b1, 16'd3, 1'b1, 1'b1},
        '{ROW_PKT, 16'd0,     1'b1, 16'd3, 1'b0, 1'b1},  // duplicate after completion
        '{ROW_CFG, 16'd0,     1'b0, 16'd0, 1'b0, 1'b0},  // zero total
        '{ROW_PKT, 16'd0,     1'b1, 16'd3, 1'b1, 1'b1},
        '{ROW_PKT, 16'hAAAA,  1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_CFG, 16'hFFFF,  1'b0, 16'd0, 1'b0, 1'b0},  // largest total
        '{ROW_PKT, 16'd4,     1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_PKT, 16'd67,    1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_PKT, 16'h5555,  1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_PKT, 16'd6,     1'b0, 16'd0, 1'b0, 1'b0},
        '{ROW_PKT, 16'd5,     1'b0, 16'd0, 1'b0, 1'b0}   // advance over 5 and 6
    };

    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = WIN + 16;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [swrc_pkg::FIELD_W-1:0]    cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [swrc_pkg::FIELD_W-1:0]    s_tdata   = '0;    // [15:0] received_seq
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [swrc_pkg::OUT_DATA_W-1:0] m_tdata;           // [15:0] cumulative_ack,
                                                        // [16] out_of_window,
                                                        // [17] transfer_done

    // Receiver image kept by the testbench
    logic [WIN-1:0]   seen_flags;
    int unsigned      next_seq;
    logic [SEQ_W-1:0] in_order_ack;
    logic [SEQ_W-1:0] total_limit;

    ack_result_t pending_acks[$];
    int          err_count = 0;
    int          sent      = 0;
    logic        steady    = 1'b0;   // no idling on either side while set

    sliding_window_receiver_cumulative_ack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Mark one request in the ring and advance over the in-order run.
    // total_limit is 16 bits, so it never exceeds the sequence mask.
    function automatic ack_result_t predict_ack(input logic [SEQ_W-1:0] seq);
        int unsigned s;
        int unsigned limit;
        ack_result_t r;
        s     = seq;
        limit = total_limit;
        r.oow = 1'b0;
        if (s >= limit || s >= next_seq + WIN)
            r.oow = 1'b1;
        else if (s >= next_seq)
        begin
            seen_flags[s % WIN] = 1'b1;
            if (s == next_seq)
            begin
                while (next_seq < limit && seen_flags[next_seq % WIN])
                begin
                    seen_flags[next_seq % WIN] = 1'b0;
                    next_seq++;
                end
                in_order_ack = SEQ_W'(next_seq - 1);
            end
        end
        r.cum_ack = in_order_ack;
        r.done    = (next_seq >= limit);
        return r;
    endfunction

    // Enter and leave at a falling edge. Keep s_tvalid high between
    // back-to-back requests so it is never lowered and raised in one step.
    task automatic send_request(input logic [SEQ_W-1:0] seq, input logic typed,
                                input ack_result_t want);
        ack_result_t r;
        if (!steady && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seq;
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_ack(seq);
        pending_acks.push_back(typed ? want : r);
        sent++;
        @(negedge clk);
    endtask

    // Write total_messages with the block idle: drain results, then let
    // any advance still running settle.
    task automatic write_total(input logic [SEQ_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_acks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        total_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side backpressure
    always @(negedge clk)
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 35);

    // Compare every accepted result with the oldest pending one
    always @(posedge clk)
    begin
        ack_result_t want;
        ack_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[15:0], m_tdata[16], m_tdata[17]};
            if (pending_acks.size() == 0)
            begin
                $error("result with no pending request: m_tdata %h", m_tdata);
                err_count++;
            end
            else
            begin
                want = pending_acks.pop_front();
                if (got.cum_ack !== want.cum_ack)
                begin
                    $error("cumulative_ack: expected %0d, got %0d", want.cum_ack, got.cum_ack);
                    err_count++;
                end
                if (got.oow !== want.oow)
                begin
                    $error("out_of_window: expected %0b, got %0b", want.oow, got.oow);
                    err_count++;
                end
                if (got.done !== want.done)
                begin
                    $error("transfer_done: expected %0b, got %0b", want.done, got.done);
                    err_count++;
                end
                if (m_tdata[swrc_pkg::OUT_DATA_W-1:18] !== '0)
                begin
                    $error("padding: expected 0, got %h", m_tdata[swrc_pkg::OUT_DATA_W-1:18]);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        int          phase_items;
        int          mode;
        int          blk;
        int          j;
        int          tmp;
        int unsigned base;
        int          offs[WIN];
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] tot;

        seen_flags   = '0;
        next_seq     = 0;
        in_order_ack = '0;
        total_limit  = swrc_pkg::TOTAL_RESET;

        // Hold reset, then release it at a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_total(DIRECTED[i].value);
            else
                send_request(DIRECTED[i].value, DIRECTED[i].typed,
                             '{DIRECTED[i].ack, DIRECTED[i].oow, DIRECTED[i].done});
        end

        // Random phases: pick a total, then mostly shuffled windows starting
        // at the expected number, with duplicates and noise mixed in
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
                tot = SEQ_W'($urandom_range(0, 65535));
            else if (mode == 1)
                tot = SEQ_W'($urandom_range(0, next_seq));
            else if (next_seq + 300 > 65535)
                tot = 16'hFFFF;
            else
                tot = SEQ_W'(next_seq + $urandom_range(16, 300));
            write_total(tot);

            phase_items = $urandom_range(40, 160);
            while (phase_items > 0 && sent < RANDOM_ITEMS)
            begin
                steady = (sent >= 900 && sent < 1200);
                if ($urandom_range(99) < 80)
                begin
                    // Well-formed window: every offset in shuffled order, some sent twice
                    blk  = $urandom_range(1, WIN - 1);
                    base = next_seq;
                    for (int k = 0; k < blk; k++)
                        offs[k] = k;
                    for (int k = blk - 1; k > 0; k--)
                    begin
                        j       = $urandom_range(0, k);
                        tmp     = offs[k];
                        offs[k] = offs[j];
                        offs[j] = tmp;
                    end
                    for (int k = 0; k < blk; k++)
                    begin
                        send_request(SEQ_W'(base + offs[k]), 1'b0, '0);
                        if ($urandom_range(99) < 10)
                            send_request(SEQ_W'(base + offs[k]), 1'b0, '0);
                    end
                    phase_items -= blk;
                end
                else
                begin
                    mode = $urandom_range(0, 2);
                    if (mode == 0)
                        seq = SEQ_W'($urandom_range(0, 65535));
                    else if (mode == 1 && next_seq > 0)
                        seq = SEQ_W'($urandom_range(0, next_seq - 1));
                    else
                        seq = SEQ_W'(next_seq + WIN + $urandom_range(0, 8));
                    send_request(seq, 1'b0, '0);
                    phase_items--;
                end
            end
        end
        steady = 1'b0;

        // Drain: drop valid, wait out every pending result and the latency
        s_tvalid <= 1'b0;
        while (pending_acks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_count == 0 && pending_acks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/swrc_pkg.sv
src/swrc_ram.sv
src/swrc_classify.sv
src/sliding_window_receiver_cumulative_ack.sv
tb/sv/sliding_window_receiver_cumulative_ack_tb.sv
